// File: rtl/b64d_pkg.sv
// Shared types and codes for the base64 stream decoder.
package b64d_pkg;

  localparam int unsigned LenWidth    = 24;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [1:0] StatusLength  = 2'd0;
  localparam logic [1:0] StatusPad     = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  typedef struct packed {
    logic [23:0]         word;
    logic [1:0]          nbytes;
    logic                has_status;
    logic [1:0]          status;
    logic [LenWidth-1:0] base_count;
  } job_t;

endpackage

// File: rtl/base64_stream_decoder_core.sv
// Top level of the base64 stream decoder.
// Takes one base64 character per input beat and accepts a new beat every cycle while the
// job queue has room. A character gives zero to four output beats: up to three decoded
// bytes and, at the end of a message, one status beat with tlast set. The output
// sequencer sends one beat per cycle while the receiver is ready, so a character that
// completes a group at the end of a message yields up to four beats; the job queue keeps
// the input flowing in bursts, and output backpressure alone sets the sustained rate.
// The capacity register resets to the largest value and should be written only while idle.
module base64_stream_decoder_core
  import b64d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [LenWidth-1:0] cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // in_byte
  input  logic                s_tlast,   // in_last
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,   // out_byte, out_status, decoded_length, zero pad
  output logic                m_tuser,   // out_kind
  output logic                m_tlast    // out_last
);

  logic accept;
  logic job_valid;
  job_t job;
  logic full;
  logic pop;
  logic head_valid;
  job_t head_job;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .job_valid (job_valid),
    .job       (job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_job   (job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// File: rtl/b64d_front.sv
// Front end: classify input characters, gather sextets, check capacity, build jobs.
module b64d_front
  import b64d_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [LenWidth-1:0] cfg_wdata,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                job_valid,
  output job_t                job
);

  logic [LenWidth-1:0] capacity;
  logic [17:0]         sextet_hold, sextet_hold_next;
  logic [1:0]          held_count, held_count_next;
  logic [LenWidth-1:0] byte_count, byte_count_next;
  logic                draining, draining_next;

  logic        is_sext, is_crlf, is_pad;
  logic [5:0]  sext;
  logic [17:0] hold_shift;
  logic [23:0] word;
  logic [2:0]  n;
  logic        emit;
  logic        ovf;
  logic [1:0]  nbytes;
  logic [1:0]  status;
  logic [LenWidth-1:0] count_after;

  function automatic logic [23:0] left_align(input logic [17:0] h, input logic [1:0] cnt);
    logic [23:0] r;
    unique case (cnt)
      2'd1:    r = {h[5:0], 18'd0};
      2'd2:    r = {h[11:0], 12'd0};
      2'd3:    r = {h, 6'd0};
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    is_sext = 1'b1;
    sext    = 6'd0;
    if (in_byte >= 8'h41 && in_byte <= 8'h5a) begin
      sext = 6'(in_byte - 8'h41);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h7a) begin
      sext = 6'(in_byte - 8'h61 + 8'd26);
    end else if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      sext = 6'(in_byte - 8'h30 + 8'd52);
    end else if (in_byte == 8'h2b) begin
      sext = 6'd62;
    end else if (in_byte == 8'h2f) begin
      sext = 6'd63;
    end else begin
      is_sext = 1'b0;
    end
    is_crlf = (in_byte == 8'h0d) || (in_byte == 8'h0a);
    is_pad  = (in_byte == 8'h3d);
  end

  assign hold_shift = {sextet_hold[11:0], sext};

  always_comb begin
    word = 24'd0;
    n    = 3'd0;
    emit = 1'b0;
    sextet_hold_next = sextet_hold;
    held_count_next  = held_count;
    priority if (draining) begin
      emit = 1'b0;
    end else if (is_sext && held_count == 2'd3) begin
      word = {sextet_hold, sext};
      n    = 3'd4;
      sextet_hold_next = 18'd0;
      held_count_next  = 2'd0;
    end else if (is_sext) begin
      if (in_last) begin
        word = left_align(hold_shift, held_count + 2'd1);
        n    = {1'b0, held_count} + 3'd1;
        emit = 1'b1;
      end else begin
        sextet_hold_next = hold_shift;
        held_count_next  = held_count + 2'd1;
      end
    end else if (is_crlf) begin
      if (in_last) begin
        word = left_align(sextet_hold, held_count);
        n    = {1'b0, held_count};
        emit = 1'b1;
      end
    end else begin
      word = left_align(sextet_hold, held_count);
      n    = {1'b0, held_count};
      emit = 1'b1;
    end

    ovf    = (n != 3'd0) && (({1'b0, byte_count} + 25'd3) > {1'b0, capacity});
    nbytes = (ovf || n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
    if (!draining && n == 3'd4 && (ovf || in_last)) begin
      emit = 1'b1;
    end
    priority if (ovf) begin
      status = StatusOverflow;
    end else if (is_sext || is_crlf) begin
      status = StatusLength;
    end else if (is_pad) begin
      status = StatusPad;
    end else begin
      status = StatusInvalid;
    end
    count_after = byte_count + LenWidth'(nbytes);

    byte_count_next = count_after;
    draining_next   = draining;
    if (draining) begin
      byte_count_next = byte_count;
    end
    if ((draining || emit) && in_last) begin
      sextet_hold_next = 18'd0;
      held_count_next  = 2'd0;
      byte_count_next  = '0;
      draining_next    = 1'b0;
    end else if (emit) begin
      sextet_hold_next = 18'd0;
      held_count_next  = 2'd0;
      draining_next    = 1'b1;
    end
  end

  assign job_valid      = accept && !draining && (nbytes != 2'd0 || emit);
  assign job.word       = word;
  assign job.nbytes     = nbytes;
  assign job.has_status = emit;
  assign job.status     = status;
  assign job.base_count = byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= '1;
      sextet_hold <= '0;
      held_count  <= '0;
      byte_count  <= '0;
      draining    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        sextet_hold <= sextet_hold_next;
        held_count  <= held_count_next;
        byte_count  <= byte_count_next;
        draining    <= draining_next;
      end
    end
  end

endmodule

// File: rtl/b64d_queue.sv
// Small job queue between the front end and the output sequencer.
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  job_t                mem [DEPTH];
  logic [PtrWidth-1:0] wr_ptr, rd_ptr;
  logic [CntWidth-1:0] count;

  assign full       = (count == CntWidth'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/b64d_back.sv
// Back end: expand each job into its data beats and any status beat on the output register.
module b64d_back
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  logic [1:0] idx;
  logic       load;
  logic       is_data;
  logic [2:0] total;
  logic       job_done;
  logic [7:0] sel_byte;
  logic [LenWidth-1:0] len;

  assign load     = job_valid && (!m_tvalid || m_tready);
  assign is_data  = (idx < job.nbytes);
  assign total    = {1'b0, job.nbytes} + {2'b00, job.has_status};
  assign job_done = (({1'b0, idx} + 3'd1) == total);
  assign pop      = load && job_done;

  always_comb begin
    unique case (idx)
      2'd0:    sel_byte = job.word[23:16];
      2'd1:    sel_byte = job.word[15:8];
      default: sel_byte = job.word[7:0];
    endcase
    if (is_data) begin
      len = job.base_count + LenWidth'(idx) + LenWidth'(1);
    end else begin
      len = job.base_count + LenWidth'(job.nbytes);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= job_done ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (is_data) begin
        m_tdata <= {6'd0, len, StatusLength, sel_byte};
        m_tuser <= 1'b0;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= {6'd0, len, job.status, 8'd0};
        m_tuser <= 1'b1;
        m_tlast <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/b64d_checker.sv
// Port checker for the base64 stream decoder, bound to the top level.
module b64d_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == m_tuser))
    else $error("tlast and status kind disagree");

  a_data_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[9:8] == 2'd0))
    else $error("data beat carries a status code");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[7:0] == 8'd0))
    else $error("status beat carries a data byte");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for base64_stream_decoder_core: directed texts, capacity limits,
// random messages and a long output stall, all checked against a cycle-free decoder model.
module testbench
  import b64d_pkg::*;
();

  localparam logic            KindData    = 1'b0;
  localparam logic            KindStatus  = 1'b1;
  localparam logic [7:0]      CharCr      = 8'h0d;
  localparam logic [7:0]      CharLf      = 8'h0a;
  localparam logic [7:0]      CharPad     = 8'h3d;
  localparam logic [23:0]     CapacityMax = 24'hffffff;
  localparam int              IdlePercent = 16;
  localparam int              RandomItems = 240;
  localparam int              MaxReports  = 10;

  typedef struct packed {
    logic                kind;
    logic [7:0]          data;
    logic [1:0]          status;
    logic [LenWidth-1:0] len;
    logic                last;
  } beat_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wen;
  logic [LenWidth-1:0] cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [39:0]         m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  // decoder model state
  logic [23:0] capacity;
  logic [17:0] sextet_hold;
  logic [1:0]  held;
  logic [23:0] out_count;
  bit          draining_msg;
  beat_t       due_beats[$];

  bit    idle_on = 1'b1;
  int    hold_cycles = 0;
  int    mismatches = 0;
  int    beats_checked = 0;
  int    sent_chars = 0;
  int    counted_chars = 0;
  int    messages = 0;
  int    cap_writes = 0;
  int    status_seen[4] = '{0, 0, 0, 0};
  beat_t got_beat;
  beat_t want_beat;

  base64_stream_decoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic int sextet_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] b64_char(int s);
    if (s < 26) return 8'("A" + s);
    if (s < 52) return 8'("a" + s - 26);
    if (s < 62) return 8'("0" + s - 52);
    if (s == 62) return "+";
    return "/";
  endfunction

  function automatic logic [7:0] invalid_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (sextet_value(c) >= 0 || c == CharCr || c == CharLf);
    return c;
  endfunction

  function automatic void push_beat(logic kind, logic [7:0] data, logic [1:0] status,
                                    logic [23:0] len, logic last);
    due_beats.push_back(beat_t'{kind, data, status, len, last});
  endfunction

  function automatic void clear_message();
    sextet_hold = '0;
    held = '0;
    out_count = '0;
    draining_msg = 1'b0;
  endfunction

  function automatic logic [23:0] pending_word();
    return {6'b0, sextet_hold} << (6 * (4 - held));
  endfunction

  // emit n-1 bytes of a left-aligned group, or refuse if the buffer lacks room for three
  function automatic bit flush_group(logic [23:0] w, int n);
    if ({1'b0, out_count} + 25'd3 > {1'b0, capacity}) return 1'b0;
    for (int i = 0; i < n - 1; i++) begin
      out_count = out_count + 1'b1;
      push_beat(KindData, w[23 - 8 * i -: 8], StatusLength, out_count, 1'b0);
    end
    return 1'b1;
  endfunction

  // returns 1 when the character is dropped while draining
  function automatic bit decode_char(logic [7:0] c, logic last);
    int          s;
    logic [1:0]  st;
    logic [23:0] w;
    if (draining_msg) begin
      if (last) clear_message();
      return 1'b1;
    end
    s = sextet_value(c);
    if (s >= 0) begin
      if (held == 2'd3) begin
        w = {sextet_hold, s[5:0]};
        sextet_hold = '0;
        held = '0;
        if (!flush_group(w, 4)) begin
          push_beat(KindStatus, 8'h00, StatusOverflow, out_count, 1'b1);
          if (last) clear_message();
          else draining_msg = 1'b1;
          return 1'b0;
        end
      end else begin
        sextet_hold = {sextet_hold[11:0], s[5:0]};
        held = held + 1'b1;
      end
    end else if (c != CharCr && c != CharLf) begin
      st = (c == CharPad) ? StatusPad : StatusInvalid;
      if (held != 0 && !flush_group(pending_word(), held)) st = StatusOverflow;
      push_beat(KindStatus, 8'h00, st, out_count, 1'b1);
      if (last) clear_message();
      else begin
        sextet_hold = '0;
        held = '0;
        draining_msg = 1'b1;
      end
      return 1'b0;
    end
    if (last) begin
      st = StatusLength;
      if (held != 0 && !flush_group(pending_word(), held)) st = StatusOverflow;
      push_beat(KindStatus, 8'h00, st, out_count, 1'b1);
      clear_message();
    end
    return 1'b0;
  endfunction

  task automatic note_mismatch(string what, beat_t want, beat_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display({"%0t %s: expected kind %0d byte %02h status %0d len %0d last %0d,",
                " got kind %0d byte %02h status %0d len %0d last %0d"},
               $time, what, want.kind, want.data, want.status, want.len, want.last,
               got.kind, got.data, got.status, got.len, got.last);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= !(idle_on && $urandom_range(0, 99) < IdlePercent);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_beat = beat_t'{m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[33:10], m_tlast};
      beats_checked++;
      if (got_beat.kind == KindStatus) status_seen[got_beat.status]++;
      if (due_beats.size() == 0) begin
        note_mismatch("unexpected beat", '0, got_beat);
      end else begin
        want_beat = due_beats.pop_front();
        if (got_beat !== want_beat) note_mismatch("beat mismatch", want_beat, got_beat);
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic last);
    while (idle_on && $urandom_range(0, 99) < IdlePercent) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!decode_char(c, last)) counted_chars++;
    sent_chars++;
    if (last) messages++;
  endtask

  task automatic send_string(string chars, bit close);
    for (int i = 0; i < chars.len(); i++)
      send_char(chars[i], close && i == chars.len() - 1);
  endtask

  task automatic send_text(logic [7:0] text[$]);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  // drop valid, let every expected beat arrive, then let the pipeline settle
  task automatic wait_quiet();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (due_beats.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_capacity(logic [23:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    capacity = value;
    cap_writes++;
    cfg_wen <= 1'b0;
  endtask

  task automatic send_random_message();
    logic [7:0] text[$];
    int         n;
    int         mode;
    n = $urandom_range(0, 13);
    mode = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) text.push_back($urandom_range(0, 1) ? CharCr : CharLf);
      text.push_back(b64_char($urandom_range(0, 63)));
    end
    if (mode == 6 || mode == 7) begin
      text.push_back(CharPad);
      if ($urandom_range(0, 1)) text.push_back(CharPad);
    end else if (mode == 8) begin
      text.push_back(invalid_char());
    end else if (mode == 9) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
    end
    if (mode >= 6) repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
    if (text.size() == 0) text.push_back(b64_char($urandom_range(0, 63)));
    send_text(text);
  endtask

  task automatic test_known_strings();
    send_string("TWFu", 1'b1);
    send_string("QQ==", 1'b1);
    send_char("+", 1'b0);
    send_char("/", 1'b0);
    send_char(CharCr, 1'b0);
    send_char(CharLf, 1'b0);
    send_char("9", 1'b1);
    send_char("A", 1'b0);
    send_char("z", 1'b0);
    send_char("0", 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    send_string("Q", 1'b1);
    send_char(CharLf, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(CharPad, 1'b1);
    wait_quiet();
  endtask

  task automatic test_capacity_limit();
    write_capacity(24'd0);
    send_string("QUJD", 1'b1);
    send_string("QUJD", 1'b0);
    send_string("xy", 1'b1);
    send_string("QU=", 1'b1);
    send_string("Q", 1'b1);
    wait_quiet();
    write_capacity(24'd3);
    send_string("QUJDRA", 1'b1);
    wait_quiet();
    write_capacity(CapacityMax);
    send_string("QUJDRE", 1'b0);
    wait_quiet();
    write_capacity(24'd5);
    send_string("Fg", 1'b1);
    wait_quiet();
    write_capacity(24'd6);
    send_string("QUJDREVG", 1'b1);
    wait_quiet();
  endtask

  task automatic test_random_text();
    int start;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_capacity(CapacityMax);
        1: write_capacity(24'($urandom_range(0, 30)));
        2: begin
          idle_on = 1'b0;
          write_capacity(24'($urandom_range(6, 200)));
        end
        3: write_capacity(24'($urandom));
        default: write_capacity(CapacityMax);
      endcase
      start = counted_chars;
      while (counted_chars - start < RandomItems / 5) send_random_message();
      wait_quiet();
      idle_on = 1'b1;
    end
  endtask

  // hold the output off so the job queue fills and input stalls
  task automatic test_output_stall();
    hold_cycles <= 150;
    repeat (12) begin
      for (int j = 0; j < 4; j++) send_char(b64_char($urandom_range(0, 63)), j == 3);
    end
    wait_quiet();
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    m_tready  <= 1'b0;
    capacity = CapacityMax;
    clear_message();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_known_strings();
    test_capacity_limit();
    test_random_text();
    test_output_stall();
    mismatches += due_beats.size();
    $display("testbench: %0d messages, %0d characters (%0d decoded), %0d beats checked",
             messages, sent_chars, counted_chars, beats_checked);
    $display({"testbench: endings length %0d pad %0d invalid %0d overflow %0d,",
              " %0d capacity writes"},
             status_seen[StatusLength], status_seen[StatusPad], status_seen[StatusInvalid],
             status_seen[StatusOverflow], cap_writes);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder_core.sv
rtl/b64d_checker.sv
tb/sv/testbench.sv
